[design/tme_pkg.sv]
// ----------------------------------------------------------------------------
// tme_pkg: shared definitions for the text to Morse encoder
// Symbol codes, sequencer states and the ITU character pattern lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package tme_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned SymbolWidth = 3;
    localparam int unsigned PatWidth    = 6;
    localparam int unsigned LenWidth    = 3;

    localparam logic [SymbolWidth-1:0] SYM_DOT  = 3'd0;
    localparam logic [SymbolWidth-1:0] SYM_DASH = 3'd1;
    localparam logic [SymbolWidth-1:0] SYM_LGAP = 3'd2;
    localparam logic [SymbolWidth-1:0] SYM_WGAP = 3'd3;
    localparam logic [SymbolWidth-1:0] SYM_UNK  = 3'd4;

    localparam logic [CharWidth-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_UNK,
        ST_LGAP,
        ST_WGAP
    } state_t;

    // Pattern is left aligned: the first element sent sits in the top bit,
    // a one is a dash. A length of zero marks a character with no pattern.
    typedef struct packed {
        logic [LenWidth-1:0] len;
        logic [PatWidth-1:0] bits;
    } morse_entry_t;

    localparam morse_entry_t ALPHA_TABLE [26] = '{
        '{3'd2, 6'b010000}, '{3'd4, 6'b100000}, '{3'd4, 6'b101000},
        '{3'd3, 6'b100000}, '{3'd1, 6'b000000}, '{3'd4, 6'b001000},
        '{3'd3, 6'b110000}, '{3'd4, 6'b000000}, '{3'd2, 6'b000000},
        '{3'd4, 6'b011100}, '{3'd3, 6'b101000}, '{3'd4, 6'b010000},
        '{3'd2, 6'b110000}, '{3'd2, 6'b100000}, '{3'd3, 6'b111000},
        '{3'd4, 6'b011000}, '{3'd4, 6'b110100}, '{3'd3, 6'b010000},
        '{3'd3, 6'b000000}, '{3'd1, 6'b100000}, '{3'd3, 6'b001000},
        '{3'd4, 6'b000100}, '{3'd3, 6'b011000}, '{3'd4, 6'b100100},
        '{3'd4, 6'b101100}, '{3'd4, 6'b110000}
    };

    localparam morse_entry_t DIGIT_TABLE [10] = '{
        '{3'd5, 6'b111110}, '{3'd5, 6'b011110}, '{3'd5, 6'b001110},
        '{3'd5, 6'b000110}, '{3'd5, 6'b000010}, '{3'd5, 6'b000000},
        '{3'd5, 6'b100000}, '{3'd5, 6'b110000}, '{3'd5, 6'b111000},
        '{3'd5, 6'b111100}
    };

    function automatic morse_entry_t morse_lookup(input logic [CharWidth-1:0] code);
        morse_entry_t entry;
        logic [CharWidth-1:0] offset;
        entry  = '{3'd0, 6'b000000};
        offset = 8'h00;
        case (code) inside
            [8'h61:8'h7A]: begin
                offset = code - 8'h61;
                entry  = ALPHA_TABLE[offset[4:0]];
            end
            [8'h41:8'h5A]: begin
                offset = code - 8'h41;
                entry  = ALPHA_TABLE[offset[4:0]];
            end
            [8'h30:8'h39]: begin
                offset = code - 8'h30;
                entry  = DIGIT_TABLE[offset[3:0]];
            end
            8'h2E:   entry = '{3'd6, 6'b010101};
            8'h2C:   entry = '{3'd6, 6'b110011};
            8'h3F:   entry = '{3'd6, 6'b001100};
            8'h27:   entry = '{3'd6, 6'b011110};
            8'h21:   entry = '{3'd6, 6'b101011};
            8'h2F:   entry = '{3'd5, 6'b100100};
            8'h28:   entry = '{3'd5, 6'b101100};
            8'h29:   entry = '{3'd6, 6'b101101};
            8'h3A:   entry = '{3'd6, 6'b111000};
            8'h3B:   entry = '{3'd6, 6'b101010};
            8'h3D:   entry = '{3'd5, 6'b100010};
            8'h2B:   entry = '{3'd5, 6'b010100};
            8'h2D:   entry = '{3'd6, 6'b100001};
            8'h22:   entry = '{3'd6, 6'b010010};
            8'h40:   entry = '{3'd6, 6'b011010};
            default: entry = '{3'd0, 6'b000000};
        endcase
        return entry;
    endfunction

endpackage

`default_nettype wire

[design/text_to_morse_encoder.sv]
// ----------------------------------------------------------------------------
// text_to_morse_encoder: ITU Morse encoder, one character in, symbols out
// The first symbol is offered in the cycle after the character transfer.
// A character of N results holds the input for N transfers, paced by one
// shifter that walks the pattern one element per output transfer.
// Reset (aresetn low, synchronous) returns the sequencer to idle, no output.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_morse_encoder
    import tme_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire logic [CharWidth-1:0]   s_char_code,

    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      logic [SymbolWidth-1:0] m_symbol,
    output      logic                   m_last
);

    // The sequencer walks one character at a time. The pattern register is
    // the shared unit: each element transfer shifts it left by one place and
    // counts down the remaining element count, so the top bit always holds
    // the element currently on offer.
    state_t              state_reg, state_next;
    logic [PatWidth-1:0] pat_reg, pat_next;
    logic [LenWidth-1:0] cnt_reg, cnt_next;

    morse_entry_t entry;
    logic         s_xfer;
    logic         m_xfer;

    assign entry  = morse_lookup(s_char_code);
    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    // Next-state and datapath logic.
    always_comb begin
        state_next = state_reg;
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    pat_next = entry.bits;
                    cnt_next = entry.len;
                    if (s_char_code == CHAR_SPACE) begin
                        state_next = ST_WGAP;
                    end else if (entry.len == '0) begin
                        state_next = ST_UNK;
                    end else begin
                        state_next = ST_ELEM;
                    end
                end
            end
            ST_ELEM: begin
                if (m_xfer) begin
                    pat_next = {pat_reg[PatWidth-2:0], 1'b0};
                    cnt_next = cnt_reg - LenWidth'(1);
                    // After the final element the letter gap follows.
                    if (cnt_reg == LenWidth'(1)) begin
                        state_next = ST_LGAP;
                    end
                end
            end
            ST_UNK: begin
                if (m_xfer) begin
                    state_next = ST_LGAP;
                end
            end
            ST_LGAP, ST_WGAP: begin
                if (m_xfer) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output decode from the registered state only.
    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        m_symbol = SYM_DOT;
        m_last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_ELEM: begin
                m_valid  = 1'b1;
                m_symbol = pat_reg[PatWidth-1] ? SYM_DASH : SYM_DOT;
            end
            ST_UNK: begin
                m_valid  = 1'b1;
                m_symbol = SYM_UNK;
            end
            ST_LGAP: begin
                m_valid  = 1'b1;
                m_symbol = SYM_LGAP;
                m_last   = 1'b1;
            end
            ST_WGAP: begin
                m_valid  = 1'b1;
                m_symbol = SYM_WGAP;
                m_last   = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Pattern and count carry no reset; they are loaded on every character transfer.
    always_ff @(posedge aclk) begin
        pat_reg <= pat_next;
        cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire
